// File: src/insertion_sorter_unit_macros.svh
// ============================================================================
// Assertion macros for the insertion sorter checker
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ============================================================================
`ifndef INSERTION_SORTER_UNIT_MACROS_SVH
`define INSERTION_SORTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/iss_pkg.sv
// ============================================================================
// Insertion sorter package
// Shared widths and the structs that travel between the top level and cells.
// ============================================================================
`timescale 1ns / 1ps

package iss_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] iss_value_t;

  // Broadcast control to every cell of the chain.
  typedef struct packed {
    logic       insert;
    logic       shift;
    iss_value_t value;
  } iss_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    iss_value_t value;
    logic       valid;
    logic       keep;
  } iss_link_t;

endpackage

// File: src/iss_cell.sv
// ============================================================================
// Insertion sorter cell
// Holds one list entry; on insert it keeps, takes the new value or takes its
// lower neighbor's value, and on drain it takes its upper neighbor's value.
// ============================================================================
`timescale 1ns / 1ps

module iss_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  iss_pkg::iss_ctrl_t  ctrl,
  input  iss_pkg::iss_link_t  prev_i,
  input  iss_pkg::iss_link_t  next_i,
  output iss_pkg::iss_link_t  cur_o
);

  iss_pkg::iss_value_t value_r, value_nxt;
  logic                valid_r, valid_nxt;
  logic                keep;

  // An entry stays put when it is not greater than the new value, which
  // places equal values after the ones already stored.
  assign keep = valid_r && !(value_r > ctrl.value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      if (!keep) begin
        value_nxt = prev_i.keep ? ctrl.value : prev_i.value;
      end
      valid_nxt = valid_r | prev_i.valid;
    end else if (ctrl.shift) begin
      value_nxt = next_i.value;
      valid_nxt = next_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign cur_o.value = value_r;
  assign cur_o.valid = valid_r;
  assign cur_o.keep  = keep;

endmodule

// File: src/insertion_sorter_unit.sv
// ============================================================================
// Insertion sorter unit
// Streaming stable sorter built from a chain of compare-and-shift cells.
// ============================================================================
// Usage:
//   Values arrive on the in_ channel, one per transfer. Each is inserted into
//   the ascending list in the same cycle, so a set streams in at one transfer
//   per cycle. The transfer with in_tlast high ends the set: its value is
//   inserted too, then the list drains on the out_ channel in ascending order.
//   Values arriving while all CAPACITY cells are full are dropped and
//   out_tuser is high on every result of that set.
//   After the closing transfer the drain flag is registered, then the first
//   result is loaded into the output register; while out_tready is high,
//   results follow at one per cycle as the cell chain shifts one entry toward
//   the output each cycle. out_tlast marks the last result of the set.
//   While the chain drains, in_tready is low. Once the last result is in the
//   output register the next set may start, even if it waits there.
//   A stalled receiver holds the output register and pauses the drain.
//   Reset empties the chain, clears the overflow flag and the output valid.
// ============================================================================
`timescale 1ns / 1ps

module insertion_sorter_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // set_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // final_result
  output logic        out_tuser   // [0] overflowed
);

  iss_pkg::iss_link_t links [CAPACITY];
  iss_pkg::iss_ctrl_t ctrl;

  logic drain_r, drain_nxt;
  logic dropped_r, dropped_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;
  logic        out_last_r;
  logic        out_ovf_r;
  logic in_xfer, full, load, last_load;

  assign in_tready = !drain_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign full      = links[CAPACITY-1].valid;
  assign load      = drain_r && (!out_valid_r || out_tready);
  assign last_load = load && !links[1].valid;

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = load;
  assign ctrl.value  = in_tdata;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      iss_pkg::iss_link_t prev_link, next_link;
      if (gi == 0) begin : g_first
        // The lower boundary acts as a valid entry below every value.
        assign prev_link = '{value: '0, valid: 1'b1, keep: 1'b1};
      end else begin : g_mid
        assign prev_link = links[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_link = '{value: '0, valid: 1'b0, keep: 1'b0};
      end else begin : g_nlast
        assign next_link = links[gi+1];
      end
      iss_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .prev_i (prev_link),
        .next_i (next_link),
        .cur_o  (links[gi])
      );
    end
  endgenerate

  always_comb begin
    drain_nxt     = drain_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_xfer && full) begin
      dropped_nxt = 1'b1;
    end
    if (in_xfer && in_tlast) begin
      drain_nxt = 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
    if (last_load) begin
      drain_nxt   = 1'b0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drain_r     <= drain_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= links[0].value;
      out_last_r <= !links[1].valid;
      out_ovf_r  <= dropped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// File: src/insertion_sorter_unit_checker.sv
// ============================================================================
// Insertion sorter port checker
// Watches the top-level ports for handshake and set sequencing rules.
// ============================================================================
`timescale 1ns / 1ps
`include "insertion_sorter_unit_macros.svh"

module insertion_sorter_unit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled result stays offered with the same contents.
  `ISU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed or vanished")

  // Closing a set starts the drain, which blocks the input.
  `ISU_ASSERT_NEXT(a_drain_start, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "input still ready after the closing transfer")

  // A result that is not the last of its set means the drain is still running.
  `ISU_ASSERT_SAME(a_drain_busy, clk, rst_n, out_tvalid && out_tready && !out_tlast, !in_tready, "input ready while results of a set remain")

  // Results only exist once a set has been closed, so none right after reset.
  `ISU_ASSERT_NEXT(a_reset_idle, clk, rst_n, !$past(rst_n), !out_tvalid, "result offered right after reset")

  logic unused_in;
  assign unused_in = ^in_tdata;

endmodule

bind insertion_sorter_unit insertion_sorter_unit_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
